// ===== src/qs_pkg.sv =====
// Shared types and constants of the quicksort engine.
// Holds the input and result transfer structs; no dependencies.
`timescale 1ns / 1ps

package qs_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_final;
  } qs_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     end_of_run;
    logic                     overflow;
  } qs_out_t;

endpackage

// ===== src/quicksort_engine.sv =====
// Quicksort engine top level: element store, range stack and sort sequencer.
// Depends on qs_pkg for the transfer structs and the default capacity.
//
// Elements are loaded one per cycle until a transfer marked is_final; elements
// beyond MAX_ITEMS are dropped and flagged as overflow on every result of the
// set. The set is then sorted in place and returned in ascending order, the
// last result marked end_of_run. The input stalls from the final transfer
// until the last result has been taken. The store has one write and one read
// port with a registered read, so each compare step of a partition scan is a
// read state followed by a compare state; each partition also spends states on
// setup, pivot placement and range stack traffic, and each result is read,
// loaded and then held until it is taken. Already sorted input is the worst
// case for the running time.
`timescale 1ns / 1ps

module quicksort_engine #(
  parameter int MAX_ITEMS = qs_pkg::MAX_ITEMS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  qs_pkg::qs_in_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output qs_pkg::qs_out_t out_data
);

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int EXT_W = IDX_W + 1;

  typedef struct packed {
    logic [IDX_W-1:0] lo_idx;
    logic [IDX_W-1:0] hi_idx;
  } range_t;

  typedef enum logic [3:0] {
    S_LOAD, S_START, S_PIV_RD, S_PIV_GET, S_R_RD, S_R_CMP, S_L_RD, S_L_CMP,
    S_FIN, S_PUSH_L, S_POP, S_POP_GET, S_OUT_RD, S_OUT_LD, S_OUT_WAIT
  } state_t;

  state_t state;

  logic signed [qs_pkg::DATA_W-1:0] store_mem [MAX_ITEMS];
  logic signed [qs_pkg::DATA_W-1:0] store_rdata;
  range_t                           stack_mem [MAX_ITEMS];
  range_t                           stack_rdata;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] sp;
  logic             dropped;
  logic [IDX_W-1:0] rng_lo;
  logic [IDX_W-1:0] rng_hi;
  logic [IDX_W-1:0] p;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic [IDX_W-1:0] k;
  logic signed [qs_pkg::DATA_W-1:0] pv;

  logic                             st_we;
  logic [IDX_W-1:0]                 st_wa;
  logic signed [qs_pkg::DATA_W-1:0] st_wd;
  logic [IDX_W-1:0]                 st_ra;
  logic                             sk_we;
  logic [IDX_W-1:0]                 sk_wa;
  range_t                           sk_wd;
  logic [IDX_W-1:0]                 sk_ra;

  logic             store_full;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] sp_m1;
  logic             push_r_ok;
  logic             push_l_ok;

  assign store_full = (count >= CNT_W'(MAX_ITEMS));
  assign count_m1   = count - CNT_W'(1);
  assign sp_m1      = sp - CNT_W'(1);
  assign push_r_ok  = ({1'b0, p} + EXT_W'(1)) < {1'b0, rng_hi};
  assign push_l_ok  = ({1'b0, rng_lo} + EXT_W'(1)) < {1'b0, p};
  assign in_stall   = (state != S_LOAD);

  always_comb begin
    st_we = 1'b0;
    st_wa = p;
    st_wd = store_rdata;
    st_ra = k;
    sk_we = 1'b0;
    sk_wa = sp[IDX_W-1:0];
    sk_wd = '{lo_idx: rng_lo, hi_idx: rng_hi};
    sk_ra = sp_m1[IDX_W-1:0];
    unique case (state)
      S_LOAD: begin
        st_we = in_valid && !store_full;
        st_wa = count[IDX_W-1:0];
        st_wd = in_data.value;
      end
      S_PIV_RD: st_ra = rng_lo;
      S_R_RD:   st_ra = hi;
      S_L_RD:   st_ra = lo;
      S_R_CMP:  st_we = (store_rdata < pv);
      S_L_CMP:  st_we = (store_rdata > pv);
      S_FIN: begin
        st_we = 1'b1;
        st_wd = pv;
        sk_we = push_r_ok;
        sk_wd = '{lo_idx: p + IDX_W'(1), hi_idx: rng_hi};
      end
      S_PUSH_L: begin
        sk_we = push_l_ok;
        sk_wd = '{lo_idx: rng_lo, hi_idx: p - IDX_W'(1)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wa] <= st_wd;
    end
    store_rdata <= store_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (sk_we) begin
      stack_mem[sk_wa] <= sk_wd;
    end
    stack_rdata <= stack_mem[sk_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      sp        <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (store_full) begin
              dropped <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
            if (in_data.is_final) begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          k      <= '0;
          rng_lo <= '0;
          rng_hi <= count_m1[IDX_W-1:0];
          state  <= (count >= CNT_W'(2)) ? S_PIV_RD : S_OUT_RD;
        end
        S_PIV_RD: state <= S_PIV_GET;
        S_PIV_GET: begin
          pv    <= store_rdata;
          p     <= rng_lo;
          lo    <= rng_lo;
          hi    <= rng_hi;
          state <= S_R_RD;
        end
        S_R_RD: state <= (hi == p) ? S_FIN : S_R_CMP;
        S_R_CMP: begin
          if (store_rdata < pv) begin
            p     <= hi;
            state <= S_L_RD;
          end else begin
            hi    <= hi - IDX_W'(1);
            state <= S_R_RD;
          end
        end
        S_L_RD: state <= (lo == p) ? S_FIN : S_L_CMP;
        S_L_CMP: begin
          if (store_rdata > pv) begin
            p     <= lo;
            state <= S_R_RD;
          end else begin
            lo    <= lo + IDX_W'(1);
            state <= S_L_RD;
          end
        end
        S_FIN: begin
          if (sk_we) begin
            sp <= sp + CNT_W'(1);
          end
          state <= S_PUSH_L;
        end
        S_PUSH_L: begin
          if (sk_we) begin
            sp <= sp + CNT_W'(1);
          end
          state <= S_POP;
        end
        S_POP: begin
          if (sp == '0) begin
            state <= S_OUT_RD;
          end else begin
            sp    <= sp_m1;
            state <= S_POP_GET;
          end
        end
        S_POP_GET: begin
          rng_lo <= stack_rdata.lo_idx;
          rng_hi <= stack_rdata.hi_idx;
          state  <= S_PIV_RD;
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          out_data.sorted_value <= store_rdata;
          out_data.end_of_run   <= (k == count_m1[IDX_W-1:0]);
          out_data.overflow     <= dropped;
          out_valid             <= 1'b1;
          state                 <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (out_data.end_of_run) begin
              count   <= '0;
              sp      <= '0;
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              k     <= k + IDX_W'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== src/qs_checker.sv =====
// Port-level checker for the quicksort engine, bound to the top level.
// Depends on qs_pkg for the transfer structs.
`timescale 1ns / 1ps

module qs_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input qs_pkg::qs_in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input qs_pkg::qs_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while results pending");

  a_reopen_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.end_of_run |=> !in_stall && !out_valid)
    else $error("input not reopened after last result");

  a_keep_loading: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !in_data.is_final |=> !in_stall && !out_valid)
    else $error("load phase left before final element");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind quicksort_engine qs_checker u_qs_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for quicksort_engine: directed sets from a table, then random sets.
// Predicts each sorted set in SystemVerilog and checks every result transfer.
// Depends on qs_pkg (src/qs_pkg.sv) and src/quicksort_engine.sv.
`timescale 1ns / 1ps

module tb_top;

  localparam int CAPACITY = qs_pkg::MAX_ITEMS_DEF;
  localparam int ITEM_GOAL = 370;
  localparam int CALM_AFTER = 330;

  typedef logic signed [qs_pkg::DATA_W-1:0] elem_t;
  typedef elem_t elem_q_t[$];
  typedef qs_pkg::qs_out_t result_q_t[$];

  typedef struct packed {
    qs_pkg::qs_in_t  item;
    logic            typed;
    qs_pkg::qs_out_t want;
  } plan_row_t;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            in_stall;
  qs_pkg::qs_in_t  in_data;
  logic            out_valid;
  logic            out_stall;
  qs_pkg::qs_out_t out_data;

  elem_q_t   held_values;
  bit        lost_any;
  result_q_t sorted_q;

  plan_row_t plan[$];

  bit calm;
  bit hold_req;
  int hold_len;

  int errors;
  int items_sent;
  int sets_done;
  int overflow_sets;
  int results_seen;

  quicksort_engine uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic elem_q_t sort_values(elem_q_t v);
    elem_t key;
    int    j;
    for (int i = 1; i < v.size(); i++) begin
      key = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > key) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = key;
    end
    return v;
  endfunction

  // Store one element; on the final one, return the whole set in ascending order.
  function automatic result_q_t absorb_element(qs_pkg::qs_in_t it);
    result_q_t       res;
    elem_q_t         ordered;
    qs_pkg::qs_out_t r;
    if (held_values.size() < CAPACITY) held_values.push_back(it.value);
    else lost_any = 1'b1;
    if (!it.is_final) return res;
    ordered = sort_values(held_values);
    for (int k = 0; k < ordered.size(); k++) begin
      r.sorted_value = ordered[k];
      r.end_of_run   = (k == ordered.size() - 1);
      r.overflow     = lost_any;
      res.push_back(r);
    end
    sets_done++;
    if (lost_any) overflow_sets++;
    held_values.delete();
    lost_any = 1'b0;
    return res;
  endfunction

  function automatic plan_row_t mk_row(elem_t v, logic fin, logic typed);
    plan_row_t row;
    row.item.value        = v;
    row.item.is_final     = fin;
    row.typed             = typed;
    row.want.sorted_value = typed ? v : '0;
    row.want.end_of_run   = typed;
    row.want.overflow     = 1'b0;
    return row;
  endfunction

  task automatic deliver(qs_pkg::qs_in_t it, logic typed, qs_pkg::qs_out_t want);
    int        gap;
    result_q_t res;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    res = absorb_element(it);
    if (typed) sorted_q.push_back(want);
    else foreach (res[k]) sorted_q.push_back(res[k]);
  endtask

  task automatic send_set(int n, int pattern);
    elem_q_t        vals;
    elem_q_t        flipped;
    elem_t          v;
    qs_pkg::qs_in_t it;
    for (int k = 0; k < n; k++) begin
      case (pattern)
        1: v = elem_t'(int'($urandom_range(0, 6)) - 3);
        4: begin
          case ($urandom_range(0, 3))
            0: v = {1'b1, {(qs_pkg::DATA_W-1){1'b0}}};
            1: v = {1'b0, {(qs_pkg::DATA_W-1){1'b1}}};
            2: v = elem_t'(int'($urandom_range(0, 1)) - 1);
            default: v = $urandom;
          endcase
        end
        default: v = $urandom;
      endcase
      vals.push_back(v);
    end
    if (pattern == 2 || pattern == 3) vals = sort_values(vals);
    if (pattern == 3) begin
      foreach (vals[k]) flipped.push_front(vals[k]);
      vals = flipped;
    end
    for (int k = 0; k < n; k++) begin
      it.value    = vals[k];
      it.is_final = (k == n - 1);
      deliver(it, 1'b0, '0);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    qs_pkg::qs_out_t w;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (sorted_q.size() == 0) begin
        $error("unexpected result transfer: sorted_value %0d", out_data.sorted_value);
        errors++;
      end else begin
        w = sorted_q.pop_front();
        if (out_data.sorted_value !== w.sorted_value) begin
          $error("sorted_value expected %0d actual %0d", w.sorted_value,
                 out_data.sorted_value);
          errors++;
        end
        if (out_data.end_of_run !== w.end_of_run) begin
          $error("end_of_run expected %0b actual %0b", w.end_of_run, out_data.end_of_run);
          errors++;
        end
        if (out_data.overflow !== w.overflow) begin
          $error("overflow expected %0b actual %0b", w.overflow, out_data.overflow);
          errors++;
        end
      end
    end
  end

  initial begin
    elem_t top_val;
    elem_t bot_val;
    int    n;
    int    r;
    top_val = {1'b0, {(qs_pkg::DATA_W-1){1'b1}}};
    bot_val = {1'b1, {(qs_pkg::DATA_W-1){1'b0}}};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_len = 0;
    errors = 0;
    items_sent = 0;
    sets_done = 0;
    overflow_sets = 0;
    results_seen = 0;
    lost_any = 1'b0;

    // single-element sets, then short sets through the predictor
    plan.push_back(mk_row(top_val, 1'b1, 1'b1));
    plan.push_back(mk_row(bot_val, 1'b1, 1'b1));
    plan.push_back(mk_row(0, 1'b1, 1'b1));
    plan.push_back(mk_row(-1, 1'b1, 1'b1));
    plan.push_back(mk_row(5, 1'b0, 1'b0));
    plan.push_back(mk_row(-5, 1'b1, 1'b0));
    plan.push_back(mk_row(7, 1'b0, 1'b0));
    plan.push_back(mk_row(7, 1'b0, 1'b0));
    plan.push_back(mk_row(7, 1'b1, 1'b0));
    plan.push_back(mk_row(1, 1'b0, 1'b0));
    plan.push_back(mk_row(2, 1'b0, 1'b0));
    plan.push_back(mk_row(3, 1'b0, 1'b0));
    plan.push_back(mk_row(4, 1'b1, 1'b0));
    plan.push_back(mk_row(4, 1'b0, 1'b0));
    plan.push_back(mk_row(3, 1'b0, 1'b0));
    plan.push_back(mk_row(2, 1'b0, 1'b0));
    plan.push_back(mk_row(1, 1'b1, 1'b0));
    plan.push_back(mk_row(top_val, 1'b0, 1'b0));
    plan.push_back(mk_row(bot_val, 1'b0, 1'b0));
    plan.push_back(mk_row(0, 1'b0, 1'b0));
    plan.push_back(mk_row(-1, 1'b0, 1'b0));
    plan.push_back(mk_row(1, 1'b1, 1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) deliver(plan[i].item, plan[i].typed, plan[i].want);

    // hold results of one set while the next set is offered
    hold_len = 400;
    hold_req = 1'b1;
    send_set(8, 0);
    send_set(12, 0);
    send_set(CAPACITY, 2);
    send_set($urandom_range(CAPACITY + 1, CAPACITY + 6), 0);

    while (items_sent < ITEM_GOAL) begin
      if (items_sent >= CALM_AFTER) calm = 1'b1;
      r = $urandom_range(0, 19);
      if (r == 0) n = CAPACITY;
      else if (r == 1) n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
      else if (r <= 4) n = $urandom_range(13, 40);
      else n = $urandom_range(1, 12);
      send_set(n, $urandom_range(0, 4));
    end
    in_valid <= 1'b0;

    while (sorted_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("%0d elements in %0d sets sent, %0d with dropped elements",
             items_sent, sets_done, overflow_sets);
    $display("%0d sorted results checked", results_seen);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
